// ----- rtl/core/bslc_pkg.sv -----
// Shared types, codes and helpers of the battery status LED controller.
`default_nettype none

package bslc_pkg;

    localparam int CHARGE_W    = 7;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;
    localparam int S_DATA_W    = 16;
    localparam int M_DATA_W    = 8;

    localparam logic [2:0] BREATH_PWM_MAX = 3'd7;
    localparam logic [3:0] BREATH_STEPS   = 4'd14;

    localparam logic [CFG_INDEX_W-1:0] CFG_SINGLE_LED = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_ON     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_OFF    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FULL_ON    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FULL_OFF   = 3'd4;

    localparam logic [CHARGE_W-1:0] LOW_ON_RST   = 7'd10;
    localparam logic [CHARGE_W-1:0] LOW_OFF_RST  = 7'd15;
    localparam logic [CHARGE_W-1:0] FULL_ON_RST  = 7'd100;
    localparam logic [CHARGE_W-1:0] FULL_OFF_RST = 7'd95;

    typedef enum logic [1:0] {
        FUNC_CHARGE = 2'd0,
        FUNC_USB    = 2'd1,
        FUNC_BLINK  = 2'd2,
        FUNC_BREATH = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_LOW      = 2'd1,
        MODE_CHARGING = 2'd2,
        MODE_FULL     = 2'd3
    } led_mode_t;

    // LED levels: bit 0 red, bit 1 blue, bit 2 green
    localparam logic [2:0] LED_NONE  = 3'b000;
    localparam logic [2:0] LED_RED   = 3'b001;
    localparam logic [2:0] LED_BLUE  = 3'b010;
    localparam logic [2:0] LED_GREEN = 3'b100;

    typedef struct packed {
        logic                usb_power;
        logic [CHARGE_W-1:0] charge_pct;
        func_t               func;
    } item_t;

    typedef struct packed {
        led_mode_t led_mode;
        logic      green_on;
        logic      blue_on;
        logic      red_on;
    } result_t;

    function automatic logic [2:0] breath_brightness(input logic [3:0] phase);
        logic [3:0] down;
        down = BREATH_STEPS - phase;
        if (phase <= {1'b0, BREATH_PWM_MAX})
            return phase[2:0];
        else if (phase <= BREATH_STEPS)
            return down[2:0];
        else
            return 3'd0;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/battery_status_led_controller.sv -----
// Top level of the battery status LED controller.
// One item is taken per clock cycle when the result side keeps up; each accepted item
// waits in the input register, goes through the step logic, which does the whole state
// update of an item combinationally, and is loaded into the result register for m_tdata.
// A waiting result stalls the input only once the input register is full too.
// Configuration writes are always ready and should be made while no item is in flight;
// a changed mode select sets the LED mode at the next charge or USB update.
`default_nettype none

module battery_status_led_controller
    import bslc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_DATA_W-1:0]    s_tdata,   // [1:0] func, [8:2] charge_pct, [9] usb_power
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_DATA_W-1:0]         m_tdata,   // [0] red_on, [1] blue_on, [2] green_on,
                                                   // [4:3] led_mode
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic    item_valid;
    item_t   item;
    logic    out_free;
    logic    advance;
    result_t result;

    assign advance = item_valid && out_free;

    bslc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bslc_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    bslc_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/core/bslc_in_reg.sv -----
// Input register of the controller: holds one accepted item for the step logic.
`default_nettype none

module bslc_in_reg
    import bslc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                advance,
    output logic                     item_valid,
    output item_t                    item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- rtl/core/bslc_step.sv -----
// Configuration registers, display state and the per-item step logic.
`default_nettype none

module bslc_step
    import bslc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   advance,
    input  item_t                       item,
    output result_t                     result
);

    logic                single_reg;
    logic [CHARGE_W-1:0] low_on_reg;
    logic [CHARGE_W-1:0] low_off_reg;
    logic [CHARGE_W-1:0] full_on_reg;
    logic [CHARGE_W-1:0] full_off_reg;

    led_mode_t           mode_reg,     mode_next;
    logic [CHARGE_W-1:0] charge_reg,   charge_next;
    logic                usb_reg,      usb_next;
    logic                low_lat_reg,  low_lat_next;
    logic                full_lat_reg, full_lat_next;
    logic                blink_reg,    blink_next;
    logic [3:0]          breath_reg,   breath_next;
    logic [2:0]          pwm_reg,      pwm_next;
    logic [2:0]          leds_reg,     leds_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_reg   <= 1'b0;
            low_on_reg   <= LOW_ON_RST;
            low_off_reg  <= LOW_OFF_RST;
            full_on_reg  <= FULL_ON_RST;
            full_off_reg <= FULL_OFF_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SINGLE_LED: single_reg   <= cfg_data[0];
                CFG_LOW_ON:     low_on_reg   <= cfg_data;
                CFG_LOW_OFF:    low_off_reg  <= cfg_data;
                CFG_FULL_ON:    full_on_reg  <= cfg_data;
                CFG_FULL_OFF:   full_off_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        logic refresh;
        logic pwm_wrap;

        mode_next     = mode_reg;
        charge_next   = charge_reg;
        usb_next      = usb_reg;
        low_lat_next  = low_lat_reg;
        full_lat_next = full_lat_reg;
        blink_next    = blink_reg;
        breath_next   = breath_reg;
        pwm_next      = pwm_reg;
        leds_next     = leds_reg;
        pwm_wrap      = 1'b0;

        refresh = (item.func == FUNC_CHARGE) || (item.func == FUNC_USB);
        if (item.func == FUNC_CHARGE)
            charge_next = item.charge_pct;
        if (item.func == FUNC_USB)
            usb_next = item.usb_power;

        if (refresh)
        begin
            // mode selection, with hysteresis latches outside single-LED mode
            if (single_reg)
            begin
                if (usb_next)
                    mode_next = MODE_CHARGING;
                else
                    mode_next = (charge_next < low_on_reg) ? MODE_LOW : MODE_OFF;
            end
            else if (usb_next)
            begin
                low_lat_next  = 1'b0;
                full_lat_next = full_lat_reg ? !(charge_next <= full_off_reg)
                                             : (charge_next >= full_on_reg);
                mode_next     = full_lat_next ? MODE_FULL : MODE_CHARGING;
            end
            else
            begin
                full_lat_next = 1'b0;
                low_lat_next  = low_lat_reg ? !(charge_next >= low_off_reg)
                                            : (charge_next <= low_on_reg);
                mode_next     = low_lat_next ? MODE_LOW : MODE_OFF;
            end

            // mode entry and exit actions
            if (single_reg)
            begin
                if (mode_next == MODE_CHARGING && mode_reg != MODE_CHARGING)
                begin
                    breath_next = 4'd0;
                    pwm_next    = 3'd0;
                end
            end
            else if (mode_next == MODE_LOW)
            begin
                if (mode_reg != MODE_LOW)
                    blink_next = 1'b1;
            end
            else if (mode_reg == MODE_LOW)
            begin
                blink_next = 1'b0;
            end

            // pattern of the new mode
            if (single_reg)
                leds_next = (mode_next == MODE_LOW) ? LED_RED : LED_NONE;
            else
            begin
                case (mode_next)
                    MODE_LOW:      leds_next = blink_next ? LED_RED : LED_NONE;
                    MODE_CHARGING: leds_next = LED_BLUE;
                    MODE_FULL:     leds_next = LED_GREEN;
                    default:       leds_next = LED_NONE;
                endcase
            end
        end
        else if (item.func == FUNC_BLINK)
        begin
            if (!single_reg && mode_reg == MODE_LOW)
            begin
                blink_next = !blink_reg;
                leds_next  = blink_next ? LED_RED : LED_NONE;
            end
        end
        else if (single_reg && mode_reg == MODE_CHARGING)
        begin
            pwm_next = pwm_reg + 3'd1;
            pwm_wrap = (pwm_next == 3'd0);
            if (pwm_wrap)
                breath_next = (breath_reg >= BREATH_STEPS) ? 4'd0 : breath_reg + 4'd1;
            leds_next = (pwm_next <= breath_brightness(breath_next)) ? LED_RED : LED_NONE;
        end

        result.led_mode = mode_next;
        result.red_on   = leds_next[0];
        result.blue_on  = leds_next[1] && !single_reg;
        result.green_on = leds_next[2] && !single_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_OFF;
            charge_reg   <= '0;
            usb_reg      <= 1'b0;
            low_lat_reg  <= 1'b0;
            full_lat_reg <= 1'b0;
            blink_reg    <= 1'b0;
            breath_reg   <= 4'd0;
            pwm_reg      <= 3'd0;
            leds_reg     <= LED_NONE;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            charge_reg   <= charge_next;
            usb_reg      <= usb_next;
            low_lat_reg  <= low_lat_next;
            full_lat_reg <= full_lat_next;
            blink_reg    <= blink_next;
            breath_reg   <= breath_next;
            pwm_reg      <= pwm_next;
            leds_reg     <= leds_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bslc_out_reg.sv -----
// Result register of the controller, driving the master-side stream.
`default_nettype none

module bslc_out_reg
    import bslc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  result_t                  result,
    output logic                     free,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign free       = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_DATA_W - $bits(result_t)){1'b0}}, data_reg};

endmodule

`default_nettype wire

// ----- rtl/core/bslc_checker.sv -----
// Port-level checks of the battery status LED controller and their bind.
`default_nettype none

module bslc_checker
    import bslc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tready,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [M_DATA_W-1:0]    m_tdata
);

    // a stalled result transfer holds its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // the input stalls only behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with the result side free");

    // padding above the result fields stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_DATA_W-1:$bits(result_t)] == '0)
        else $error("result padding not zero");

    // off mode lights nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4:3] == MODE_OFF |-> m_tdata[2:0] == LED_NONE)
        else $error("LED lit in off mode");

    // blue only while charging, green only while full
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1] || m_tdata[2]) |->
            (m_tdata[1] && m_tdata[4:3] == MODE_CHARGING && !m_tdata[2]) ||
            (m_tdata[2] && m_tdata[4:3] == MODE_FULL && !m_tdata[1]))
        else $error("blue or green lit in wrong mode");

endmodule

bind battery_status_led_controller bslc_checker u_bslc_checker (.*);

`default_nettype wire

// ----- tb/battery_status_led_controller_tb.sv -----
// Self-checking testbench: stream traffic into the LED controller, checked per transfer.

module battery_status_led_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bslc_pkg::*;

    class led_scoreboard;
        bit                  single;
        logic [CHARGE_W-1:0] low_on;
        logic [CHARGE_W-1:0] low_off;
        logic [CHARGE_W-1:0] full_on;
        logic [CHARGE_W-1:0] full_off;

        led_mode_t           disp;
        logic [CHARGE_W-1:0] level;
        bit                  usb;
        bit                  low_lat;
        bit                  full_lat;
        bit                  blink;
        logic [3:0]          step;
        logic [2:0]          pwm;
        logic [2:0]          leds;

        result_t             expected_leds[$];
        int unsigned         errors;
        int unsigned         checked;
        int unsigned         func_seen[4];
        int unsigned         mode_seen[4];

        function new();
            single   = 1'b0;
            low_on   = LOW_ON_RST;
            low_off  = LOW_OFF_RST;
            full_on  = FULL_ON_RST;
            full_off = FULL_OFF_RST;
            disp     = MODE_OFF;
            level    = '0;
            usb      = 1'b0;
            low_lat  = 1'b0;
            full_lat = 1'b0;
            blink    = 1'b0;
            step     = '0;
            pwm      = '0;
            leds     = LED_NONE;
            errors   = 0;
            checked  = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_SINGLE_LED: single   = val[0];
                CFG_LOW_ON:     low_on   = val;
                CFG_LOW_OFF:    low_off  = val;
                CFG_FULL_ON:    full_on  = val;
                CFG_FULL_OFF:   full_off = val;
                default: ;
            endcase
        endfunction

        // triangular breath phase: ramps 0..7 then back down, wraps after 14
        function logic [2:0] glow_level(logic [3:0] phase);
            logic [3:0] down;
            down = 4'd14 - phase;
            if (phase <= 4'd7)
                return phase[2:0];
            if (phase <= 4'd14)
                return down[2:0];
            return 3'd0;
        endfunction

        function void settle_mode();
            if (single)
            begin
                if (usb)
                    disp = MODE_CHARGING;
                else if (level < low_on)
                    disp = MODE_LOW;
                else
                    disp = MODE_OFF;
            end
            else if (usb)
            begin
                low_lat = 1'b0;
                if (full_lat)
                begin
                    if (level <= full_off)
                        full_lat = 1'b0;
                end
                else if (level >= full_on)
                    full_lat = 1'b1;
                disp = full_lat ? MODE_FULL : MODE_CHARGING;
            end
            else
            begin
                full_lat = 1'b0;
                if (low_lat)
                begin
                    if (level >= low_off)
                        low_lat = 1'b0;
                end
                else if (level <= low_on)
                    low_lat = 1'b1;
                disp = low_lat ? MODE_LOW : MODE_OFF;
            end
        endfunction

        function void paint();
            if (single)
                leds = (disp == MODE_LOW) ? LED_RED : LED_NONE;
            else
                case (disp)
                    MODE_LOW:      leds = blink ? LED_RED : LED_NONE;
                    MODE_CHARGING: leds = LED_BLUE;
                    MODE_FULL:     leds = LED_GREEN;
                    default:       leds = LED_NONE;
                endcase
        endfunction

        function void refresh_mode();
            led_mode_t was;
            was = disp;
            settle_mode();
            if (single)
            begin
                if (disp == MODE_CHARGING && was != MODE_CHARGING)
                begin
                    step = '0;
                    pwm  = '0;
                end
            end
            else if (disp == MODE_LOW)
            begin
                if (was != MODE_LOW)
                    blink = 1'b1;
            end
            else if (was == MODE_LOW)
                blink = 1'b0;
            paint();
        endfunction

        function void note_input(item_t it);
            result_t r;
            func_seen[it.func]++;
            case (it.func)
                FUNC_CHARGE:
                begin
                    level = it.charge_pct;
                    refresh_mode();
                end
                FUNC_USB:
                begin
                    usb = it.usb_power;
                    refresh_mode();
                end
                FUNC_BLINK:
                begin
                    if (!single && disp == MODE_LOW)
                    begin
                        blink = ~blink;
                        paint();
                    end
                end
                default:
                begin
                    if (single && disp == MODE_CHARGING)
                    begin
                        pwm = pwm + 3'd1;
                        if (pwm == 3'd0)
                            step = (step >= 4'd14) ? 4'd0 : step + 4'd1;
                        leds = (pwm <= glow_level(step)) ? LED_RED : LED_NONE;
                    end
                end
            endcase
            r.red_on   = leds[0];
            r.blue_on  = single ? 1'b0 : leds[1];
            r.green_on = single ? 1'b0 : leds[2];
            r.led_mode = disp;
            mode_seen[disp]++;
            expected_leds.push_back(r);
        endfunction

        function void compare(string what, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                if (errors < 50)
                    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_leds(logic [M_DATA_W-1:0] data);
            result_t got;
            result_t want;
            got = result_t'(data[4:0]);
            if (expected_leds.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none, got 0x%02h", $time, data);
                errors++;
            end
            else
            begin
                want = expected_leds.pop_front();
                checked++;
                compare("red_on", 8'(want.red_on), 8'(got.red_on));
                compare("blue_on", 8'(want.blue_on), 8'(got.blue_on));
                compare("green_on", 8'(want.green_on), 8'(got.green_on));
                compare("led_mode", 8'(want.led_mode), 8'(got.led_mode));
                compare("pad bits", 8'd0, 8'(data[M_DATA_W-1:5]));
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bit                     calm;
    int unsigned            settings_used;
    led_scoreboard          sb = new();

    battery_status_led_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic drive_item(input func_t f, input logic [CHARGE_W-1:0] pct, input logic u);
        item_t               it;
        logic [S_DATA_W-1:0] word;
        it.func       = f;
        it.charge_pct = pct;
        it.usb_power  = u;
        word          = '0;
        word[$bits(item_t)-1:0] = it;
        while (!calm && $urandom_range(99) < 12)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(it);
    endtask

    // stop offering and let every predicted transfer come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_leds.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic load_regs(input logic [CFG_DATA_W-1:0] sel, lo_on, lo_off, fu_on, fu_off);
        logic [CFG_INDEX_W-1:0] idx [5];
        logic [CFG_DATA_W-1:0]  val [5];
        idx = '{CFG_SINGLE_LED, CFG_LOW_ON, CFG_LOW_OFF, CFG_FULL_ON, CFG_FULL_OFF};
        val = '{sel, lo_on, lo_off, fu_on, fu_off};
        for (int i = 0; i < 5; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] sel, lo_on, lo_off, fu_on, fu_off,
                             input int count, input bit steady);
        func_t               f;
        int                  r;
        int                  t;
        logic [CHARGE_W-1:0] pct;
        logic                u;
        settle();
        load_regs(sel, lo_on, lo_off, fu_on, fu_off);
        repeat (count)
        begin
            r = $urandom_range(99);
            if (sb.single)
                f = (r < 8) ? FUNC_CHARGE : (r < 12) ? FUNC_USB :
                    (r < 18) ? FUNC_BLINK : FUNC_BREATH;
            else
                f = (r < 45) ? FUNC_CHARGE : (r < 60) ? FUNC_USB :
                    (r < 90) ? FUNC_BLINK : FUNC_BREATH;
            // charge mostly lands right around a threshold
            r = $urandom_range(99);
            if (r < 60)
            begin
                case ($urandom_range(3))
                    0:       t = int'(sb.low_on);
                    1:       t = int'(sb.low_off);
                    2:       t = int'(sb.full_on);
                    default: t = int'(sb.full_off);
                endcase
                if (sb.single)
                    t = int'(sb.low_on);
                t = t + int'($urandom_range(4)) - 2;
                if (t < 0)
                    t = 0;
                pct = t[CHARGE_W-1:0];
            end
            else if (r < 85)
                pct = CHARGE_W'($urandom_range(100));
            else
                pct = CHARGE_W'($urandom_range(127));
            if (steady)
                u = 1'b1;
            else if (sb.single)
                u = ($urandom_range(99) < 85);
            else
                u = 1'($urandom_range(1));
            drive_item(f, pct, u);
        end
    endtask

    initial
    begin : result_sink
        int unsigned hold;
        bit          held_once;
        hold      = 0;
        held_once = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_leds(m_tdata);
            if (hold != 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (!held_once && sb.checked >= 300)
            begin
                // long back-pressure so the block fills and stalls its input
                held_once = 1'b1;
                hold      = 80;
                m_tready <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 12);
        end
    end

    initial
    begin : stimulus
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_SINGLE_LED;
        cfg_data  <= '0;
        calm      = 1'b0;
        settings_used = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // three-LED defaults: blink, hysteresis, full latch, charge above 100
        drive_item(FUNC_CHARGE, 7'd0, 1'b0);
        repeat (3) drive_item(FUNC_BLINK, 7'd0, 1'b0);
        drive_item(FUNC_BREATH, 7'd0, 1'b0);
        drive_item(FUNC_CHARGE, 7'd15, 1'b0);
        drive_item(FUNC_BLINK, 7'd0, 1'b0);
        drive_item(FUNC_CHARGE, 7'd10, 1'b0);
        drive_item(FUNC_USB, 7'd0, 1'b1);
        drive_item(FUNC_CHARGE, 7'd100, 1'b0);
        drive_item(FUNC_CHARGE, 7'd127, 1'b0);
        drive_item(FUNC_CHARGE, 7'd95, 1'b0);
        drive_item(FUNC_USB, 7'd0, 1'b0);
        drive_item(FUNC_CHARGE, 7'd3, 1'b0);

        // single mode: held levels until an update, then steady red and breathing
        settle();
        load_regs(7'd1, LOW_ON_RST, LOW_OFF_RST, FULL_ON_RST, FULL_OFF_RST);
        drive_item(FUNC_BLINK, 7'd0, 1'b0);
        drive_item(FUNC_CHARGE, 7'd9, 1'b0);
        drive_item(FUNC_USB, 7'd0, 1'b1);
        repeat (8) drive_item(FUNC_BREATH, 7'd0, 1'b0);
        drive_item(FUNC_USB, 7'd0, 1'b0);

        run_phase(7'd0, 7'd10, 7'd15, 7'd100, 7'd95, 100, 1'b0);
        run_phase(7'd1, 7'd10, 7'd15, 7'd100, 7'd95, 150, 1'b0);
        run_phase(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 90, 1'b0);
        run_phase(7'd1, 7'd100, 7'd100, 7'd0, 7'd0, 110, 1'b0);
        calm = 1'b1;
        run_phase(7'd0, 7'd100, 7'd100, 7'd100, 7'd100, 90, 1'b0);
        calm = 1'b0;
        run_phase(7'd1, 7'd50, 7'd50, 7'd50, 7'd50, 260, 1'b1);
        run_phase(7'd0, 7'd50, 7'd20, 7'd30, 7'd60, 90, 1'b0);
        run_phase(7'd1, 7'd0, 7'd0, 7'd100, 7'd100, 100, 1'b0);
        run_phase(7'd0, CHARGE_W'($urandom_range(100)), CHARGE_W'($urandom_range(100)),
                  CHARGE_W'($urandom_range(100)), CHARGE_W'($urandom_range(100)), 80, 1'b0);

        settle();
        repeat (4) @(posedge clk);
        $display("Checked %0d transfers (charge %0d, usb %0d, blink %0d, breath %0d), %0d settings",
                 sb.checked, sb.func_seen[FUNC_CHARGE], sb.func_seen[FUNC_USB],
                 sb.func_seen[FUNC_BLINK], sb.func_seen[FUNC_BREATH], settings_used);
        $display("Modes predicted: off %0d, low %0d, charging %0d, full %0d; %0d errors",
                 sb.mode_seen[MODE_OFF], sb.mode_seen[MODE_LOW], sb.mode_seen[MODE_CHARGING],
                 sb.mode_seen[MODE_FULL], sb.errors);
        if (sb.errors == 0 && sb.expected_leds.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("Timeout with %0d transfers outstanding", sb.expected_leds.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
